// File: hdl/atilt_pkg.sv
`default_nettype none
package atilt_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 18;

  // Operand, radicand and root formats (independent of the sample width)
  localparam int OP_W      = 32;
  localparam int RAD_W     = 64;
  localparam int ROOT_BITS = 32;
  localparam int REM_W     = 35;

  // CORDIC datapath
  localparam int CX_W      = 36;
  localparam int ACC_W     = 33;
  localparam int TABLE_LEN = 24;

  // Angle conversion: mag = floor(floor(ua * SCALE_NUM / 2^30) / DIV_K)
  localparam int ANGLE_W   = 11;
  localparam int ANGLE_MAX = 899;
  localparam int SCALE_NUM = 2250000;
  localparam int ANGLE_SH  = 30;
  localparam int DIV_K     = 3927;
  localparam int RECIP_M   = 4374807;
  localparam int RECIP_SH  = 34;
  localparam int PROD_W    = 53;
  localparam int Q_W       = 23;
  localparam int EST_W     = 12;

  localparam logic [1:0] FUNC_Z    = 2'd0;
  localparam logic [1:0] FUNC_X    = 2'd1;
  localparam logic [1:0] FUNC_Y    = 2'd2;
  localparam logic [1:0] FUNC_ZERO = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_req_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_tenths;
    logic                      degenerate;
  } out_req_t;

  typedef struct packed {
    logic            is_zero_func;
    logic            neg;
    logic            hyp_num;
    logic            num_zero;
    logic            den_zero;
    logic [OP_W-1:0] lin;
  } side_t;

  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'd843314856;
      1:       v = 32'd497837829;
      2:       v = 32'd263043836;
      3:       v = 32'd133525158;
      4:       v = 32'd67021686;
      5:       v = 32'd33543515;
      6:       v = 32'd16775850;
      7:       v = 32'd8388437;
      8:       v = 32'd4194282;
      9:       v = 32'd2097149;
      10:      v = 32'd1048575;
      11:      v = 32'd524287;
      12:      v = 32'd262143;
      13:      v = 32'd131071;
      14:      v = 32'd65535;
      15:      v = 32'd32767;
      16:      v = 32'd16383;
      17:      v = 32'd8191;
      18:      v = 32'd4095;
      19:      v = 32'd2047;
      20:      v = 32'd1023;
      21:      v = 32'd511;
      22:      v = 32'd255;
      23:      v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/accel_tilt_angle.sv
`default_nettype none
// Channel   Ports                         Moves
// input     in_valid, in_ready, in_req    func + x/y/z samples, one request per item
// result    out_valid, out_ready, out_req angle_tenths + degenerate, one per item
//
// One request enters every cycle while the pipeline advances; an output stall holds it off.
// Stages: capture/select, square, sum, 32 square-root digit stages, operand setup,
// CORDIC_STEPS vectoring stages, three conversion stages, output register.
// The whole pipeline advances together whenever the output register is empty or taken;
// on a stall every stage holds, so nothing is dropped or repeated.
// rst_n (synchronous, active low) clears only the valid bits.
module accel_tilt_angle
  import atilt_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_req_t      out_req
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int FRAC    = OP_W - SW;
  localparam int ST_SQ0  = 3;
  localparam int ST_SET  = ST_SQ0 + ROOT_BITS;
  localparam int ST_COR0 = ST_SET + 1;
  localparam int ST_CA   = ST_COR0 + CORDIC_STEPS;
  localparam int ST_CB   = ST_CA + 1;
  localparam int ST_CC   = ST_CB + 1;
  localparam int NS      = ST_CC + 2;

  logic adv;
  logic vld_r [NS];
  side_t side_r [ST_CC+1];

  // advance the whole pipe when the output slot is free or being taken
  assign adv       = !vld_r[NS-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // ---------------- stage 0: sample extraction, magnitudes, operand select
  logic [SW-1:0] sx, sy, sz;
  generate
    if (SW <= 16) begin : g_narrow
      assign sx = in_req.accel_x[SW-1:0];
      assign sy = in_req.accel_y[SW-1:0];
      assign sz = in_req.accel_z[SW-1:0];
    end else begin : g_wide
      // wider samples see the 16-bit field zero-extended
      assign sx = {{(SW-16){1'b0}}, in_req.accel_x};
      assign sy = {{(SW-16){1'b0}}, in_req.accel_y};
      assign sz = {{(SW-16){1'b0}}, in_req.accel_z};
    end
  endgenerate

  logic [SW-1:0] ax, ay, az, ha_nxt, hb_nxt, ha_r, hb_r;
  side_t side0_nxt;

  assign ax = sx[SW-1] ? (~sx + 1'b1) : sx;
  assign ay = sy[SW-1] ? (~sy + 1'b1) : sy;
  assign az = sz[SW-1] ? (~sz + 1'b1) : sz;

  always_comb begin
    side0_nxt = '0;
    ha_nxt    = '0;
    hb_nxt    = '0;
    case (in_req.func)
      FUNC_Z: begin
        ha_nxt            = ax;
        hb_nxt            = ay;
        side0_nxt.lin     = {az, {FRAC{1'b0}}};
        side0_nxt.neg     = sz[SW-1];
        side0_nxt.hyp_num = 1'b1;
      end
      FUNC_X: begin
        ha_nxt        = ay;
        hb_nxt        = az;
        side0_nxt.lin = {ax, {FRAC{1'b0}}};
        side0_nxt.neg = sx[SW-1];
      end
      FUNC_Y: begin
        ha_nxt        = ax;
        hb_nxt        = az;
        side0_nxt.lin = {ay, {FRAC{1'b0}}};
        side0_nxt.neg = sy[SW-1];
      end
      default: begin
        side0_nxt.is_zero_func = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ha_r      <= ha_nxt;
      hb_r      <= hb_nxt;
      side_r[0] <= side0_nxt;
    end
  end

  // ---------------- stage 1: squares; stage 2: sum forms the radicand
  logic [2*SW-1:0] sqa_r, sqb_r;
  logic [RAD_W-1:0] rad_r [ROOT_BITS+1];
  logic [REM_W-1:0] rem_r [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sqa_r     <= ha_r * ha_r;
      sqb_r     <= hb_r * hb_r;
      side_r[1] <= side_r[0];
      rad_r[0]  <= {sqa_r + sqb_r, {(2*FRAC){1'b0}}};
      side_r[2] <= side_r[1];
    end
  end

  // ---------------- square-root digit stages: one root bit each
  generate
    for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
      logic [REM_W-1:0]     rem_in, rem_sh, trial;
      logic [ROOT_BITS-1:0] root_in;
      if (i == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign rem_in  = rem_r[i-1];
        assign root_in = root_r[i-1];
      end
      assign rem_sh = {rem_in[REM_W-3:0], rad_r[i][RAD_W-1-2*i -: 2]};
      assign trial  = {1'b0, root_in, 2'b01};
      always_ff @(posedge clk) begin
        if (adv) begin
          rad_r[i+1]       <= rad_r[i];
          side_r[ST_SQ0+i] <= side_r[ST_SQ0+i-1];
          if (rem_sh >= trial) begin
            rem_r[i]  <= rem_sh - trial;
            root_r[i] <= {root_in[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem_r[i]  <= rem_sh;
            root_r[i] <= {root_in[ROOT_BITS-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // ---------------- setup: pick numerator/denominator, flag zeros
  logic [OP_W-1:0] num_s, den_s;
  side_t set_nxt;
  logic signed [CX_W-1:0]  cx_r [CORDIC_STEPS+1];
  logic signed [CX_W-1:0]  cy_r [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] acc_r [CORDIC_STEPS+1];

  always_comb begin
    set_nxt          = side_r[ST_SET-1];
    num_s            = set_nxt.hyp_num ? root_r[ROOT_BITS-1] : set_nxt.lin;
    den_s            = set_nxt.hyp_num ? set_nxt.lin : root_r[ROOT_BITS-1];
    set_nxt.num_zero = (num_s == '0);
    set_nxt.den_zero = (den_s == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[ST_SET] <= set_nxt;
      cx_r[0]        <= signed'({{(CX_W-OP_W){1'b0}}, den_s});
      cy_r[0]        <= signed'({{(CX_W-OP_W){1'b0}}, num_s});
      acc_r[0]       <= '0;
    end
  end

  // ---------------- CORDIC vectoring stages
  generate
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CX_W-1:0]  dx, dy;
      logic signed [ACC_W-1:0] ang;
      assign dx  = cy_r[i] >>> i;
      assign dy  = cx_r[i] >>> i;
      assign ang = signed'({1'b0, atan_entry(i)});
      always_ff @(posedge clk) begin
        if (adv) begin
          side_r[ST_COR0+i] <= side_r[ST_COR0+i-1];
          if (!cy_r[i][CX_W-1]) begin
            cx_r[i+1]  <= cx_r[i] + dx;
            cy_r[i+1]  <= cy_r[i] - dy;
            acc_r[i+1] <= acc_r[i] + ang;
          end else begin
            cx_r[i+1]  <= cx_r[i] - dx;
            cy_r[i+1]  <= cy_r[i] + dy;
            acc_r[i+1] <= acc_r[i] - ang;
          end
        end
      end
    end
  endgenerate

  // ---------------- conversion: radians to tenths of a degree
  logic [ACC_W-2:0]  ua;
  logic [PROD_W-1:0] prod_r;
  logic [Q_W-1:0]    q_c, q_r;
  logic [Q_W+23-1:0] qm;
  logic [EST_W-1:0]  est_r, mag_r, est_inc;
  logic [2*EST_W-1:0] ek;
  logic [Q_W:0]      rem_q;
  logic [EST_W-1:0]  mag_c;
  out_req_t          out_nxt, out_req_r;

  assign ua      = acc_r[CORDIC_STEPS][ACC_W-1] ? '0 : acc_r[CORDIC_STEPS][ACC_W-2:0];
  assign q_c     = prod_r[ANGLE_SH +: Q_W];
  assign qm      = q_c * 23'(RECIP_M);
  assign ek      = est_r * EST_W'(DIV_K);
  assign rem_q   = {1'b0, q_r} - ek;
  // estimate may fall one short: fix with a single compare
  assign est_inc = est_r + 1'b1;
  assign mag_c   = (rem_q >= (Q_W+1)'(DIV_K)) ? est_inc : est_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r        <= PROD_W'(ua) * PROD_W'(SCALE_NUM);
      side_r[ST_CA] <= side_r[ST_CA-1];
      q_r           <= q_c;
      est_r         <= qm[RECIP_SH +: EST_W];
      side_r[ST_CB] <= side_r[ST_CA];
      mag_r         <= mag_c;
      side_r[ST_CC] <= side_r[ST_CB];
    end
  end

  // ---------------- output: special cases, clamp, sign
  logic [ANGLE_W-1:0] mag_o;
  side_t              sf;

  always_comb begin
    sf      = side_r[ST_CC];
    out_nxt = '0;
    if (mag_r > EST_W'(ANGLE_MAX)) mag_o = ANGLE_W'(ANGLE_MAX);
    else                           mag_o = mag_r[ANGLE_W-1:0];
    if (sf.den_zero) mag_o = ANGLE_W'(ANGLE_MAX);
    if (sf.is_zero_func) begin
      out_nxt = '0;
    end else if (sf.num_zero) begin
      out_nxt.degenerate = sf.den_zero;
    end else begin
      out_nxt.angle_tenths = sf.neg ? signed'(~mag_o + 1'b1) : signed'(mag_o);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_req_r <= out_nxt;
  end

  assign out_req = out_req_r;

endmodule
`default_nettype wire

// File: sim/tilt_angle_checker.sv
module tilt_angle_checker
  import atilt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_req_t out_req,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 32 - SAMPLE_WIDTH_DEF;

  out_req_t angle_q[$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned hyp(longint unsigned a, longint unsigned b);
    return root_floor((a * a + b * b) << (2 * FRAC));
  endfunction

  function automatic longint vector_angle(longint unsigned den, longint unsigned num);
    longint cx;
    longint cy;
    longint acc;
    longint dx;
    longint dy;
    cx = den;
    cy = num;
    acc = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < TABLE_LEN; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        acc += longint'(atan_entry(i));
      end else begin
        cx -= dx;
        cy += dy;
        acc -= longint'(atan_entry(i));
      end
    end
    return acc;
  endfunction

  function automatic out_req_t tilt_of(in_req_t r);
    out_req_t o;
    longint x;
    longint y;
    longint z;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned az;
    longint unsigned num;
    longint unsigned den;
    longint unsigned mag;
    longint a;
    logic neg;
    o = '0;
    x = r.accel_x;
    y = r.accel_y;
    z = r.accel_z;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    if (r.func == FUNC_ZERO) return o;
    if (r.func == FUNC_Z) begin
      num = hyp(ax, ay);
      den = az << FRAC;
      neg = z < 0;
    end else if (r.func == FUNC_X) begin
      num = ax << FRAC;
      den = hyp(ay, az);
      neg = x < 0;
    end else begin
      num = ay << FRAC;
      den = hyp(ax, az);
      neg = y < 0;
    end
    if (num == 0 && den == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    if (num == 0) return o;
    if (den == 0) begin
      mag = ANGLE_MAX;
    end else begin
      a = vector_angle(den, num);
      mag = a < 0 ? 0 : ((unsigned'(a) * 64'd18000000) / (64'd31416 << 30));
      if (mag > ANGLE_MAX) mag = ANGLE_MAX;
    end
    o.angle_tenths = neg ? -ANGLE_W'(mag) : ANGLE_W'(mag);
    return o;
  endfunction

  task automatic report_miss(string what, int got, int want);
    $display("angle check: %s got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_req_t want;
    if (rst_n) begin
      if (in_valid && in_ready) angle_q.push_back(tilt_of(in_req));
      if (out_valid && out_ready) begin
        if (angle_q.size() == 0) begin
          report_miss("result with nothing pending", out_req.angle_tenths, 0);
        end else begin
          want = angle_q.pop_front();
          if (out_req.angle_tenths !== want.angle_tenths)
            report_miss("angle_tenths", out_req.angle_tenths, want.angle_tenths);
          if (out_req.degenerate !== want.degenerate)
            report_miss("degenerate", out_req.degenerate, want.degenerate);
        end
      end
    end
    pending = angle_q.size();
  end
endmodule

// File: sim/accel_tilt_angle_test.sv
module accel_tilt_angle_test;
  import atilt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40 + CORDIC_STEPS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_req;
  int       fail_count;
  int       pending;
  int       cycles = 0;
  // idle odds in percent for sender and receiver
  int       send_idle = 0;
  int       recv_stall = 0;
  // receiver hold-off, counted down in cycles
  int       hold_off = 0;

  always #5 clk = ~clk;

  accel_tilt_angle dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_req(out_req)
  );

  tilt_angle_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_req(out_req),
    .fail_count(fail_count), .pending(pending)
  );

  // Timeout guard: cover the worst stalls on both sides with wide margin.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: drive ready at the falling edge, honoring a hold-off first.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Send one request: optional idle gaps, then hold valid until accepted.
  // Valid stays high on return so the next request can follow with no gap.
  task automatic send(in_req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(8)) - 4);
      3: return 16'(int'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_req_t rand_req();
    in_req_t r;
    r.func = 2'($urandom_range(3));
    r.accel_x = pick_sample();
    r.accel_y = pick_sample();
    r.accel_z = pick_sample();
    // zero out some axes to hit the degenerate and right-angle cases
    if ($urandom_range(9) == 0) r.accel_x = 0;
    if ($urandom_range(9) == 0) r.accel_y = 0;
    if ($urandom_range(9) == 0) r.accel_z = 0;
    return r;
  endfunction

  task automatic mk(logic [1:0] f, int x, int y, int z);
    in_req_t r;
    r.func = f;
    r.accel_x = 16'(x);
    r.accel_y = 16'(y);
    r.accel_z = 16'(z);
    send(r);
  endtask

  // Drop valid and pause until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every selector, extremes, zero over zero, zero numerator,
    // zero denominator, and near right angles.
    mk(FUNC_Z, 0, 0, 0);
    mk(FUNC_X, 0, 0, 0);
    mk(FUNC_Y, 0, 0, 0);
    mk(FUNC_ZERO, 32767, -32768, 100);
    mk(FUNC_Z, 0, 0, 1000);
    mk(FUNC_Z, 0, 0, -1000);
    mk(FUNC_X, 0, 5, 5);
    mk(FUNC_Z, 300, 0, 0);
    mk(FUNC_X, -300, 0, 0);
    mk(FUNC_Y, 0, -32768, 0);
    mk(FUNC_Y, 0, 32767, 0);
    mk(FUNC_Z, 32767, 32767, 1);
    mk(FUNC_Z, -32768, -32768, -1);
    mk(FUNC_X, 32767, 1, 0);
    mk(FUNC_X, -32768, -32768, -32768);
    mk(FUNC_Y, 32767, 32767, 32767);
    mk(FUNC_Y, 1, 1, 1);
    mk(FUNC_Z, 1, 0, 1);
    mk(FUNC_X, -1, 0, 1);
    mk(FUNC_Z, -1, -1, -1);
    mk(FUNC_Y, 1000, -1000, 1000);
    drain();

    // Long receiver hold-off while the sender keeps offering requests.
    hold_off <= 300;
    for (int i = 0; i < 80; i++) send(rand_req());
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 68; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 68; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      for (int i = 0; i < 75; i++) send(rand_req());
    end

    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/atilt_pkg.sv
hdl/accel_tilt_angle.sv
sim/tilt_angle_checker.sv
sim/accel_tilt_angle_test.sv
